/* hdl/izpn_pkg.sv */
// ----------------------------------------------------------------------------
// izpn_pkg
// types, constants and fixed-point helpers shared by the neuron step block
// ----------------------------------------------------------------------------
package izpn_pkg;

    localparam int DIV_STEPS = 2;
    localparam int POISSON_SCALE = 1000;

    localparam logic signed [31:0] VT_RESET = -32'sd2621440;
    localparam logic signed [31:0] VR_RESET = -32'sd3932160;
    localparam logic [30:0] INV_CAP_RESET = 31'd655;
    localparam logic signed [31:0] A_RESET = 32'sd1966;
    localparam logic signed [31:0] B_RESET = 32'sd13107;
    localparam logic signed [31:0] C_RESET = -32'sd3276800;
    localparam logic signed [31:0] D_RESET = 32'sd524288;
    localparam logic signed [31:0] U_RESET = -32'sd786420;

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_REST      = 3'd1,
        CFG_INV_CAP   = 3'd2,
        CFG_RATE_A    = 3'd3,
        CFG_SENS_B    = 3'd4,
        CFG_AFTER_C   = 3'd5,
        CFG_JUMP_D    = 3'd6,
        CFG_GAIN      = 3'd7
    } cfg_addr_t;

    typedef struct packed {
        logic signed [31:0] vt;
        logic signed [31:0] vr;
        logic [30:0]        inv_cap;
        logic signed [31:0] a_rate;
        logic signed [31:0] b_sens;
        logic signed [31:0] c_pot;
        logic signed [31:0] d_jump;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_GAIN  = 4'd0,
        OP_S1_A  = 4'd1,
        OP_S1_B  = 4'd2,
        OP_S1_C  = 4'd3,
        OP_S1_V  = 4'd4,
        OP_S2_A  = 4'd5,
        OP_S2_B  = 4'd6,
        OP_S2_C  = 4'd7,
        OP_S2_V  = 4'd8,
        OP_DRIVE = 4'd9,
        OP_ARATE = 4'd10,
        OP_REC   = 4'd11,
        OP_POIS  = 4'd12
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_WB,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic wb;
        logic finish;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        if (x > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33($signed({a[31], a}) + $signed({b[31], b}));
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33($signed({a[31], a}) - $signed({b[31], b}));
    endfunction

    function automatic logic signed [31:0] qprod(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        if (s > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (s < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // shift-subtract divide, used only when building constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8*idx/depth) in Q16.16 from an integer series for exp
    function automatic logic [31:0] tanh_entry(input int depth, input int idx);
        logic [63:0] one;
        logic [63:0] z;
        logic [63:0] term;
        logic signed [63:0] r;
        logic [63:0] p;
        logic [63:0] e;
        one = 64'd1 << 30;
        z = udiv64(64'd16 << 30, 64'(depth));
        term = one;
        r = $signed(one);
        for (int n = 1; n <= 24; n++) begin
            term = udiv64((term * z) >> 30, 64'(n));
            if ((n % 2) == 1) begin
                r = r - $signed(term);
            end else begin
                r = r + $signed(term);
            end
        end
        if (r < 0) begin
            r = 0;
        end
        if (r > $signed(one)) begin
            r = $signed(one);
        end
        p = one;
        for (int j = 1; j <= idx; j++) begin
            p = (p * $unsigned(r)) >> 30;
        end
        e = udiv64((one - p) << 16, one + p);
        return e[31:0];
    endfunction

endpackage

/* hdl/izpn_regs.sv */
// ----------------------------------------------------------------------------
// izpn_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module izpn_regs import izpn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                CFG_THRESHOLD: cfg_next.vt = cfg_wdata[31:0];
                CFG_REST:      cfg_next.vr = cfg_wdata[31:0];
                CFG_INV_CAP:   cfg_next.inv_cap = cfg_wdata[30:0];
                CFG_RATE_A:    cfg_next.a_rate = cfg_wdata[31:0];
                CFG_SENS_B:    cfg_next.b_sens = cfg_wdata[31:0];
                CFG_AFTER_C:   cfg_next.c_pot = cfg_wdata[31:0];
                CFG_JUMP_D:    cfg_next.d_jump = cfg_wdata[31:0];
                CFG_GAIN: begin
                    cfg_next.k1 = cfg_wdata[31:0];
                    cfg_next.k2 = cfg_wdata[63:32];
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vt <= VT_RESET;
            cfg_reg.vr <= VR_RESET;
            cfg_reg.inv_cap <= INV_CAP_RESET;
            cfg_reg.a_rate <= A_RESET;
            cfg_reg.b_sens <= B_RESET;
            cfg_reg.c_pot <= C_RESET;
            cfg_reg.d_jump <= D_RESET;
            cfg_reg.k1 <= '0;
            cfg_reg.k2 <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/izpn_ctrl.sv */
// ----------------------------------------------------------------------------
// izpn_ctrl
// sequencer: step division, shared multiplier op sequence, result handoff
// ----------------------------------------------------------------------------
module izpn_ctrl import izpn_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg;
    state_t     state_next;
    op_t        op_reg;
    op_t        op_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= OP_GAIN;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        cnt_next = cnt_reg;
        s_ready = 1'b0;
        cmd = '0;
        cmd.op = op_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    op_next = OP_GAIN;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                cmd.wb = 1'b1;
                if (op_reg == OP_POIS) begin
                    state_next = ST_FIN;
                end else begin
                    op_next = op_t'(op_reg + 4'd1);
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DIV))
        else $error("accepted transaction did not start division");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= 5'(DIV_STEPS)))
        else $error("division counter out of range");

    a_finish_from_last_op: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (op_reg == OP_POIS))
        else $error("finish before op sequence completed");

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !status.out_busy)
        else $error("finish while result still pending");

endmodule

/* hdl/izpn_dp.sv */
// ----------------------------------------------------------------------------
// izpn_dp
// datapath: step divider, tanh table, shared 32x32 multiplier, state, output
// ----------------------------------------------------------------------------
module izpn_dp import izpn_pkg::*; #(
    parameter int TICKS_PER_MILLISECOND = 1024,
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  cfg_t        cfg,
    input  logic [31:0] s_drift_ticks,
    input  logic [31:0] s_elapsed_ticks,
    input  logic signed [31:0] s_applied_current,
    input  logic [30:0] s_spike_rate,
    input  logic [15:0] s_random_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_step_ticks,
    output logic [31:0] m_spike_time,
    output logic        m_membrane_spike,
    output logic        m_poisson_spike
);

    localparam int TW = $clog2(TICKS_PER_MILLISECOND + 1);
    localparam int DW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int SW = 32 + DW;
    localparam int IW = $clog2(TANH_TABLE_DEPTH);
    localparam int PW = TW + 18;
    localparam int XW = TW + 17;
    localparam logic [17:0] RECIP =
        18'((64'd1 << (16 + TW)) / 64'(TICKS_PER_MILLISECOND));

    logic [TW-1:0]      ticks_reg;
    logic [16:0]        q0_reg;
    logic [16:0]        tstep_reg;
    logic [31:0]        drift_reg;
    logic signed [31:0] cur_reg;
    logic [30:0]        rate_reg;
    logic [15:0]        frac_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] vc_reg;
    logic signed [31:0] k_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] th_reg;
    logic signed [63:0] prod_reg;
    logic               pspike_reg;

    logic               m_valid_reg;
    logic [31:0]        step_ticks_reg;
    logic [31:0]        spike_time_reg;
    logic               mspike_out_reg;
    logic               pspike_out_reg;

    // step clamp, reciprocal estimate and one correction step
    logic [31:0]   ticks_full;
    logic [PW-1:0] rprod;
    logic [XW-1:0] qt;
    logic [XW-1:0] xr;
    logic          corr;
    assign ticks_full = (s_elapsed_ticks > 32'(TICKS_PER_MILLISECOND)) ?
                        32'(TICKS_PER_MILLISECOND) : s_elapsed_ticks;
    assign rprod = PW'(ticks_reg) * PW'(RECIP);
    assign qt = XW'(q0_reg) * XW'(TICKS_PER_MILLISECOND);
    assign xr = {1'b0, ticks_reg, 16'd0} - qt;
    assign corr = (xr >= XW'(TICKS_PER_MILLISECOND));

    // tanh lookup
    logic [31:0] tanh_rom [TANH_TABLE_DEPTH];
    for (genvar gi = 0; gi < TANH_TABLE_DEPTH; gi++) begin : g_tanh
        assign tanh_rom[gi] = tanh_entry(TANH_TABLE_DEPTH, gi);
    end

    logic signed [31:0] dvt;
    logic [31:0]        mag;
    logic [SW-1:0]      scaled;
    logic [SW-1:0]      idx_full;
    logic [IW-1:0]      idx;
    logic [31:0]        entry;
    assign dvt = qsub(v_reg, cfg.vt);
    assign mag = dvt[31] ? (~dvt + 32'd1) : dvt;
    assign scaled = SW'(mag) * SW'(TANH_TABLE_DEPTH);
    assign idx_full = scaled >> 19;
    assign idx = (idx_full > SW'(TANH_TABLE_DEPTH - 1)) ?
                 IW'(TANH_TABLE_DEPTH - 1) : idx_full[IW-1:0];
    assign entry = tanh_rom[idx];

    // multiplier operands
    logic signed [31:0] tstep_s;
    logic signed [31:0] half_s;
    logic signed [31:0] rest_s;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [31:0] q;
    logic [63:0]        pois_thr;
    assign tstep_s = {15'd0, tstep_reg};
    assign half_s = {16'd0, tstep_reg[16:1]};
    assign rest_s = tstep_s - half_s;
    assign q = qprod(prod_reg);
    assign pois_thr = (64'(frac_reg) * 64'(POISSON_SCALE)) << 16;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            OP_GAIN: begin
                op_a = cfg.k2;
                op_b = th_reg;
            end
            OP_S1_A, OP_S2_A: begin
                op_a = k_reg;
                op_b = qsub(vc_reg, cfg.vr);
            end
            OP_S1_B, OP_S2_B: begin
                op_a = t_reg;
                op_b = qsub(vc_reg, cfg.vt);
            end
            OP_S1_C, OP_S2_C: begin
                op_a = t_reg;
                op_b = {1'b0, cfg.inv_cap};
            end
            OP_S1_V: begin
                op_a = half_s;
                op_b = t_reg;
            end
            OP_S2_V: begin
                op_a = rest_s;
                op_b = t_reg;
            end
            OP_DRIVE: begin
                op_a = cfg.b_sens;
                op_b = qsub(vc_reg, cfg.vr);
            end
            OP_ARATE: begin
                op_a = tstep_s;
                op_b = cfg.a_rate;
            end
            OP_REC: begin
                op_a = k_reg;
                op_b = t_reg;
            end
            OP_POIS: begin
                op_a = tstep_s;
                op_b = {1'b0, rate_reg};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ticks_reg <= ticks_full[TW-1:0];
            tstep_reg <= '0;
            drift_reg <= s_drift_ticks;
            cur_reg <= s_applied_current;
            rate_reg <= s_spike_rate;
            frac_reg <= s_random_fraction;
            vc_reg <= v_reg;
        end
        if (cmd.div_step) begin
            q0_reg <= 17'(rprod >> TW);
            tstep_reg <= q0_reg + 17'(corr);
            th_reg <= dvt[31] ? -$signed(entry) : $signed(entry);
        end
        if (cmd.mul) begin
            prod_reg <= op_a * op_b;
        end
        if (cmd.wb) begin
            case (cmd.op)
                OP_GAIN:                   k_reg <= qadd(cfg.k1, q);
                OP_S1_A, OP_S2_A:          t_reg <= q;
                OP_S1_B, OP_S2_B:          t_reg <= qadd(qsub(q, u_reg), cur_reg);
                OP_S1_C, OP_S2_C:          t_reg <= q;
                OP_S1_V, OP_S2_V:          vc_reg <= qadd(vc_reg, q);
                OP_DRIVE:                  t_reg <= qsub(q, u_reg);
                OP_ARATE:                  k_reg <= q;
                OP_POIS: pspike_reg <= (rate_reg != '0) && ($unsigned(prod_reg) > pois_thr);
                default:                   t_reg <= t_reg;
            endcase
        end
    end

    // neuron state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= VR_RESET;
            u_reg <= U_RESET;
        end else if (cmd.wb && (cmd.op == OP_REC)) begin
            u_reg <= qadd(u_reg, q);
        end else if (cmd.finish) begin
            if (vc_reg >= cfg.vt) begin
                v_reg <= cfg.c_pot;
                u_reg <= qadd(u_reg, cfg.d_jump);
            end else begin
                v_reg <= vc_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            step_ticks_reg <= 32'(ticks_reg);
            spike_time_reg <= drift_reg + 32'(ticks_reg);
            mspike_out_reg <= (vc_reg >= cfg.vt);
            pspike_out_reg <= pspike_reg;
        end
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid = m_valid_reg;
    assign m_step_ticks = step_ticks_reg;
    assign m_spike_time = spike_time_reg;
    assign m_membrane_spike = mspike_out_reg;
    assign m_poisson_spike = pspike_out_reg;

endmodule

/* hdl/izhikevich_poisson_neuron_step_top.sv */
// ----------------------------------------------------------------------------
// izhikevich_poisson_neuron_step_top
// one neuron: each transaction advances the membrane and recovery state by
// up to one millisecond and reports membrane and poisson spikes
// ----------------------------------------------------------------------------
// Per transaction: acceptance latches the inputs, division steps turn the
// tick count into a Q16.16 step by a reciprocal multiply and a one-step
// correction, then 13 operations, each a multiply and a write-back, on the
// shared 32x32 multiplier (gain, two half-step slope evaluations, recovery
// update, poisson compare), and a final step, held while an earlier result
// is untaken, commits state and loads the output register. One transaction
// is in flight at a time; s_ready is high only while the sequencer is idle,
// and a finished result waits in the output register as the next is taken.
module izhikevich_poisson_neuron_step_top import izpn_pkg::*; #(
    parameter int TICKS_PER_MILLISECOND = 1024,
    parameter int TANH_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_drift_ticks,
    input  logic [31:0] s_elapsed_ticks,
    input  logic signed [31:0] s_applied_current,
    input  logic [30:0] s_spike_rate,
    input  logic [15:0] s_random_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_step_ticks,
    output logic [31:0] m_spike_time,
    output logic        m_membrane_spike,
    output logic        m_poisson_spike
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    izpn_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    izpn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    izpn_dp #(
        .TICKS_PER_MILLISECOND (TICKS_PER_MILLISECOND),
        .TANH_TABLE_DEPTH      (TANH_TABLE_DEPTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg               (cfg),
        .s_drift_ticks     (s_drift_ticks),
        .s_elapsed_ticks   (s_elapsed_ticks),
        .s_applied_current (s_applied_current),
        .s_spike_rate      (s_spike_rate),
        .s_random_fraction (s_random_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_step_ticks      (m_step_ticks),
        .m_spike_time      (m_spike_time),
        .m_membrane_spike  (m_membrane_spike),
        .m_poisson_spike   (m_poisson_spike)
    );

endmodule

/* tb/tb_izhikevich_poisson_neuron_step_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_izhikevich_poisson_neuron_step_top
// drives neuron step transactions with random idling and back-pressure,
// predicts step ticks, spike time and both spike flags with a fixed-point
// model of the neuron and compares every result in order
// ----------------------------------------------------------------------------

module tb_izhikevich_poisson_neuron_step_top import izpn_pkg::*; ;

class neuron_scoreboard;
    int signed vt, vr, inv_cap, a_rate, b_sens, c_pot, d_jump, k1, k2;
    int signed v_mem, u_rec;
    int signed tanh_lut[256];
    logic [33:0] pending[$];
    logic [31:0] spk_time[$];
    int errors;

    function new();
        longint unsigned one, z, term, p;
        longint r;
        one = 64'd1 << 30;
        z = (64'd16 << 30) / 256;
        term = one;
        r = one;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * z) >> 30) / n;
            if (n % 2) r = r - longint'(term);
            else r = r + longint'(term);
        end
        if (r < 0) r = 0;
        if (r > longint'(one)) r = one;
        p = one;
        for (int i = 0; i < 256; i++) begin
            if (i > 0) p = (p * longint'(r)) >> 30;
            tanh_lut[i] = int'(((one - p) << 16) / (one + p));
        end
        errors = 0;
        vt = -2621440; vr = -3932160; inv_cap = 655; a_rate = 1966;
        b_sens = 13107; c_pot = -3276800; d_jump = 524288; k1 = 0; k2 = 0;
        v_mem = vr;
        u_rec = fmul(b_sens, vr);
    endfunction

    function int signed clip(longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return int'(x);
    endfunction

    function int signed fadd(int signed a, int signed b);
        return clip(longint'(a) + longint'(b));
    endfunction

    function int signed fsub(int signed a, int signed b);
        return clip(longint'(a) - longint'(b));
    endfunction

    function int signed fmul(int signed a, int signed b);
        return clip((longint'(a) * longint'(b)) >>> 16);
    endfunction

    function int signed ftanh(int signed x);
        longint mag;
        longint idx;
        mag = x < 0 ? -longint'(x) : longint'(x);
        idx = (mag * 256) >> 19;
        if (idx > 255) idx = 255;
        return x < 0 ? -tanh_lut[idx] : tanh_lut[idx];
    endfunction

    function int signed slope(int signed k, int signed v, int signed u, int signed cur);
        int signed t;
        t = fmul(k, fsub(v, vr));
        t = fmul(t, fsub(v, vt));
        t = fsub(t, u);
        t = fadd(t, cur);
        return fmul(t, inv_cap);
    endfunction

    function void set_reg(cfg_addr_t idx, logic [63:0] val);
        case (idx)
            CFG_THRESHOLD: vt = val[31:0];
            CFG_REST:      vr = val[31:0];
            CFG_INV_CAP:   inv_cap = {1'b0, val[30:0]};
            CFG_RATE_A:    a_rate = val[31:0];
            CFG_SENS_B:    b_sens = val[31:0];
            CFG_AFTER_C:   c_pot = val[31:0];
            CFG_JUMP_D:    d_jump = val[31:0];
            CFG_GAIN: begin
                k1 = val[31:0];
                k2 = val[63:32];
            end
            default: ;
        endcase
    endfunction

    function void note_input(logic [31:0] drift, logic [31:0] elapsed, int signed cur,
                             logic [30:0] rate, logic [15:0] frac);
        logic [31:0] ticks;
        int signed tstep, half, rest, v, u, k, drive;
        logic ms, ps;
        ticks = elapsed > 1024 ? 32'd1024 : elapsed;
        tstep = (ticks << 16) / 1024;
        half = tstep >>> 1;
        rest = tstep - half;
        v = v_mem;
        u = u_rec;
        k = fadd(k1, fmul(k2, ftanh(fsub(v, vt))));
        v = fadd(v, fmul(half, slope(k, v, u, cur)));
        v = fadd(v, fmul(rest, slope(k, v, u, cur)));
        drive = fsub(fmul(b_sens, fsub(v, vr)), u);
        u = fadd(u, fmul(fmul(tstep, a_rate), drive));
        ms = 0;
        if (v >= vt) begin
            v = c_pot;
            u = fadd(u, d_jump);
            ms = 1;
        end
        ps = rate != 0 && longint'(tstep) * longint'(rate) >
             longint'(1000) * (longint'(frac) << 16);
        v_mem = v;
        u_rec = u;
        pending.insert(pending.size(), {ticks, ms, ps});
        spk_time.insert(spk_time.size(), drift + ticks);
    endfunction

    function void check_result(logic [31:0] st, logic [31:0] tm, logic ms, logic ps);
        logic [33:0] e;
        logic [31:0] et;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result ticks %0d", $time, st);
            errors++;
            return;
        end
        e = pending.pop_front();
        et = spk_time.pop_front();
        if (st !== e[33:2]) begin
            $display("%0t: step_ticks exp %0d got %0d", $time, e[33:2], st);
            errors++;
        end
        if (tm !== et) begin
            $display("%0t: spike_time exp %0d got %0d", $time, et, tm);
            errors++;
        end
        if (ms !== e[1]) begin
            $display("%0t: membrane_spike exp %0b got %0b", $time, e[1], ms);
            errors++;
        end
        if (ps !== e[0]) begin
            $display("%0t: poisson_spike exp %0b got %0b", $time, e[0], ps);
            errors++;
        end
    endfunction
endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_addr = '0;
    logic [63:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [31:0] s_drift_ticks = '0;
    logic [31:0] s_elapsed_ticks = '0;
    logic signed [31:0] s_applied_current = '0;
    logic [30:0] s_spike_rate = '0;
    logic [15:0] s_random_fraction = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [31:0] m_step_ticks, m_spike_time;
    logic m_membrane_spike, m_poisson_spike;

    int send_idle = 14;
    int recv_idle = 59;
    bit recv_hold = 0;
    neuron_scoreboard sb;

    izhikevich_poisson_neuron_step_top u_top (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(s_drift_ticks, s_elapsed_ticks, s_applied_current,
                          s_spike_rate, s_random_fraction);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_step_ticks, m_spike_time, m_membrane_spike, m_poisson_spike);
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(cfg_addr_t idx, logic [63:0] val);
        cfg_wr_en <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    // s_valid stays high after the last transaction until drain lowers it
    task automatic send_step(logic [31:0] drift, logic [31:0] elapsed, logic [31:0] cur,
                             logic [30:0] rate, logic [15:0] frac);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_drift_ticks <= drift;
        s_elapsed_ticks <= elapsed;
        s_applied_current <= cur;
        s_spike_rate <= rate;
        s_random_fraction <= frac;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic rand_step();
        logic [31:0] el;
        logic [31:0] cur;
        logic [30:0] rate;
        case ($urandom_range(9))
            0: el = $urandom();
            1: el = 0;
            default: el = $urandom_range(1100);
        endcase
        case ($urandom_range(7))
            0: cur = $urandom();
            default: cur = $signed($urandom_range(40 << 16)) - (10 << 16);
        endcase
        rate = $urandom_range(3) == 0 ? 31'($urandom()) :
               ($urandom_range(5) == 0 ? 31'd0 : 31'($urandom_range(200 << 16)));
        send_step($urandom(), el, cur, rate, 16'($urandom()));
    endtask

    task automatic rand_config(bit extreme);
        cfg_addr_t idx;
        for (int i = 0; i < 8; i++) begin
            idx = cfg_addr_t'(i);
            if (extreme)
                write_reg(idx, $urandom_range(1) ? 64'h8000_0000_8000_0000
                                                 : 64'h7fff_ffff_7fff_ffff);
            else
                write_reg(idx, {$urandom(), $urandom()});
        end
    endtask

    task automatic set_typical();
        write_reg(CFG_THRESHOLD, 64'(-32'sd2621440));
        write_reg(CFG_REST, 64'(-32'sd3932160));
        write_reg(CFG_INV_CAP, 64'd6553);
        write_reg(CFG_RATE_A, 64'd1966);
        write_reg(CFG_SENS_B, 64'd13107);
        write_reg(CFG_AFTER_C, 64'(-32'sd3276800));
        write_reg(CFG_JUMP_D, 64'd524288);
        write_reg(CFG_GAIN, {32'd45875, 32'd45875});
    endtask

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: reset settings, then extremes
        send_step(0, 0, 0, 0, 0);
        send_step(32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 0);
        send_step(32'hffff_fc00, 1024, 32'h8000_0000, 31'h7fff_ffff, 16'hffff);
        send_step(5, 1025, 32'h0100_0000, 31'd1000 << 16, 16'hffff);
        send_step(7, 512, 32'h0100_0000, 31'd0, 16'd0);
        send_step(9, 1, 32'h0200_0000, 31'd1, 16'd0);
        drain();
        set_typical();
        for (int i = 0; i < 12; i++)
            send_step($urandom(), i * 100, 32'h0064_0000, 31'd100 << 16, 16'($urandom()));
        drain();
        rand_config(1);
        send_step(1, 1024, 32'h7fff_ffff, 31'h7fff_ffff, 16'h8000);
        send_step(2, 300, 32'h8000_0000, 31'd5, 16'd0);
        drain();
        write_reg(CFG_THRESHOLD, 64'h7fff_ffff);
        write_reg(CFG_INV_CAP, 64'h7fff_ffff);
        write_reg(CFG_GAIN, 64'h8000_0000_8000_0000);
        send_step(3, 1024, 32'h7fff_ffff, 31'd0, 16'd0);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin
                send_idle = 59;
                recv_idle = 14;
            end
            if (ph == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ph % 2 == 0) set_typical();
            else rand_config(0);
            if (ph == 1) begin
                recv_hold = 1;
                fork
                    begin
                        repeat (400) @(posedge aclk);
                        recv_hold = 0;
                    end
                    for (int i = 0; i < 5; i++) rand_step();
                join
            end
            for (int i = 0; i < 120; i++) rand_step();
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* files.f */
hdl/izpn_pkg.sv
hdl/izpn_regs.sv
hdl/izpn_ctrl.sv
hdl/izpn_dp.sv
hdl/izhikevich_poisson_neuron_step_top.sv
tb/tb_izhikevich_poisson_neuron_step_top.sv
